FILE: rtl/core/fht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IP fragment hole tracker package
// Shared types, register indexes, status codes and control structures.
// ----------------------------------------------------------------------------
package fht_pkg;

    localparam int NUM_CONTEXTS_DEF = 8;
    localparam int MAX_HOLES_DEF    = 16;
    localparam int UNIT_SHIFT       = 3;

    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_MAX_DATAGRAM_LAST = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_STORE_LIMIT       = CFG_ADDR_W'(1);

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_FULL     = 2'd1;
    localparam logic [1:0] STS_OVERFLOW = 2'd2;
    localparam logic [1:0] STS_BEYOND   = 2'd3;

    typedef struct packed {
        logic [15:0] datagram_id;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [7:0]  protocol_number;
        logic [12:0] fragment_offset;
        logic        mf_flag;
        logic [15:0] total_length;
        logic [5:0]  ihl_bytes;
    } fht_in_t;

    typedef struct packed {
        logic [2:0] context_slot;
        logic       fragment_used;
        logic       datagram_complete;
        logic [1:0] status;
    } fht_out_t;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  proto;
    } fht_key_t;

    typedef struct packed {
        logic [15:0] first;
        logic [15:0] last;
    } fht_hole_t;

    typedef struct packed {
        logic capture;
        logic key_rd;
        logic ctx_next;
        logic hit;
        logic open;
        logic full;
        logic hole_rd;
        logic hole_next;
        logic hole_eval;
        logic hole_wr2;
        logic finish;
    } fht_cmd_t;

    typedef struct packed {
        logic key_match;
        logic ctx_last;
        logic ctx_free;
        logic hole_active;
        logic hole_last;
        logic wr2_needed;
        logic out_free;
    } fht_sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/fht_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IP fragment hole tracker controller
// Sequences context search, context open, the hole walk and result delivery.
// ----------------------------------------------------------------------------
module fht_ctrl import fht_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire fht_sts_t sts,
    output fht_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY_RD,
        ST_KEY_CMP,
        ST_OPEN,
        ST_HOLE_RD,
        ST_HOLE_EVAL,
        ST_HOLE_WR2,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_KEY_RD;
                end
            end
            ST_KEY_RD: begin
                cmd.key_rd = 1'b1;
                state_next = ST_KEY_CMP;
            end
            ST_KEY_CMP: begin
                if (sts.key_match) begin
                    cmd.hit    = 1'b1;
                    state_next = ST_HOLE_RD;
                end else if (!sts.ctx_last) begin
                    cmd.ctx_next = 1'b1;
                    state_next   = ST_KEY_RD;
                end else if (sts.ctx_free) begin
                    state_next = ST_OPEN;
                end else begin
                    cmd.full   = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_OPEN: begin
                cmd.open   = 1'b1;
                state_next = ST_HOLE_RD;
            end
            ST_HOLE_RD: begin
                if (sts.hole_active) begin
                    cmd.hole_rd = 1'b1;
                    state_next  = ST_HOLE_EVAL;
                end else if (sts.hole_last) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.hole_next = 1'b1;
                end
            end
            ST_HOLE_EVAL: begin
                cmd.hole_eval = 1'b1;
                if (sts.wr2_needed) begin
                    state_next = ST_HOLE_WR2;
                end else if (sts.hole_last) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.hole_next = 1'b1;
                    state_next    = ST_HOLE_RD;
                end
            end
            ST_HOLE_WR2: begin
                cmd.hole_wr2 = 1'b1;
                if (sts.hole_last) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.hole_next = 1'b1;
                    state_next    = ST_HOLE_RD;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/core/fht_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IP fragment hole tracker datapath
// Context key table, hole descriptor memory, hole update and result register.
// ----------------------------------------------------------------------------
module fht_datapath import fht_pkg::*; #(
    parameter int NUM_CONTEXTS = NUM_CONTEXTS_DEF,
    parameter int MAX_HOLES    = MAX_HOLES_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire fht_in_t               s_data,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  m_ready,
    output logic                       m_valid,
    output fht_out_t                   m_data,
    input  wire fht_cmd_t              cmd,
    output fht_sts_t                   sts
);

    localparam int SLOT_W = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int HOLE_W = $clog2(MAX_HOLES);

    logic [15:0]             max_last_reg;
    logic [15:0]             store_limit_reg;
    logic [NUM_CONTEXTS-1:0] ctx_valid_reg;
    logic                    m_valid_reg;
    fht_out_t                m_data_reg;

    fht_in_t                 in_reg;
    logic [15:0]             first_reg;
    logic signed [17:0]      last_reg;
    logic                    len_pos_reg;
    logic [SLOT_W-1:0]       ctx_idx_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic [HOLE_W-1:0]       k_reg;
    logic [MAX_HOLES-1:0]    hv_work_reg;
    logic [MAX_HOLES-1:0]    hv_work_next;
    logic                    used_reg;
    logic                    ovf_reg;
    logic                    full_reg;
    logic [HOLE_W-1:0]       wr2_k_reg;
    fht_hole_t               wr2_data_reg;

    fht_key_t                key_mem [NUM_CONTEXTS];
    logic [MAX_HOLES-1:0]    hv_mem [NUM_CONTEXTS];
    fht_hole_t               hole_mem [NUM_CONTEXTS][MAX_HOLES];
    fht_key_t                key_rdata_reg;
    logic [MAX_HOLES-1:0]    hv_rdata_reg;
    fht_hole_t               hole_rdata_reg;

    logic [15:0]             first_c;
    logic signed [16:0]      len_c;
    logic signed [17:0]      last_c;
    fht_key_t                key_in;
    logic [SLOT_W-1:0]       free_ctx;
    logic [HOLE_W-1:0]       free_hole;
    logic                    free_found;
    logic signed [17:0]      hf_s;
    logic signed [17:0]      hl_s;
    logic signed [17:0]      first_s;
    logic                    touched;
    logic                    low;
    logic                    high;
    logic                    hwe;
    logic [SLOT_W-1:0]       hw_slot;
    logic [HOLE_W-1:0]       hw_k;
    fht_hole_t               hw_data;
    fht_hole_t               upper_piece;
    logic                    remaining;
    logic [1:0]              status_c;

    assign first_c = {s_data.fragment_offset, {UNIT_SHIFT{1'b0}}};
    assign len_c   = $signed({1'b0, s_data.total_length})
                   - $signed({11'd0, s_data.ihl_bytes});
    assign last_c  = $signed({2'b00, first_c}) + 18'(len_c) - 18'sd1;

    assign key_in = '{id: in_reg.datagram_id, src: in_reg.source_address,
                      dst: in_reg.destination_address, proto: in_reg.protocol_number};

    always_comb begin
        free_ctx = '0;
        for (int i = NUM_CONTEXTS - 1; i >= 0; i--) begin
            if (!ctx_valid_reg[i]) begin
                free_ctx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        free_hole  = '0;
        free_found = 1'b0;
        for (int i = MAX_HOLES - 1; i >= 0; i--) begin
            if (!hv_work_reg[i]) begin
                free_hole  = HOLE_W'(i);
                free_found = 1'b1;
            end
        end
    end

    assign hf_s    = $signed({2'b00, hole_rdata_reg.first});
    assign hl_s    = $signed({2'b00, hole_rdata_reg.last});
    assign first_s = $signed({2'b00, first_reg});
    assign touched = !(first_s > hl_s || last_reg < hf_s);
    assign low     = first_s > hf_s;
    assign high    = (last_reg < hl_s) && in_reg.mf_flag;

    assign upper_piece = '{first: last_reg[15:0] + 16'd1, last: hole_rdata_reg.last};

    always_comb begin
        hwe     = 1'b0;
        hw_slot = slot_reg;
        hw_k    = k_reg;
        hw_data = upper_piece;
        if (cmd.open) begin
            hwe     = 1'b1;
            hw_slot = free_ctx;
            hw_k    = '0;
            hw_data = '{first: 16'd0, last: max_last_reg};
        end else if (cmd.hole_eval && touched && (low || high)) begin
            hwe = 1'b1;
            if (low) begin
                hw_data = '{first: hole_rdata_reg.first, last: first_reg - 16'd1};
            end
        end else if (cmd.hole_wr2) begin
            hwe     = 1'b1;
            hw_k    = wr2_k_reg;
            hw_data = wr2_data_reg;
        end
    end

    always_comb begin
        hv_work_next = hv_work_reg;
        if (touched) begin
            hv_work_next[k_reg] = low || high;
            if (low && high && free_found) begin
                hv_work_next[free_hole] = 1'b1;
            end
        end
    end

    assign remaining = |hv_work_reg;

    always_comb begin
        if (ovf_reg) begin
            status_c = STS_OVERFLOW;
        end else if (used_reg && last_reg >= $signed({2'b00, store_limit_reg})) begin
            status_c = STS_BEYOND;
        end else begin
            status_c = STS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (hwe) begin
            hole_mem[hw_slot][hw_k] <= hw_data;
        end
        if (cmd.hole_rd) begin
            hole_rdata_reg <= hole_mem[slot_reg][k_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.open) begin
            key_mem[free_ctx] <= key_in;
        end
        if (cmd.key_rd) begin
            key_rdata_reg <= key_mem[ctx_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish && !full_reg) begin
            hv_mem[slot_reg] <= hv_work_reg;
        end
        if (cmd.key_rd) begin
            hv_rdata_reg <= hv_mem[ctx_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg      <= s_data;
            first_reg   <= first_c;
            last_reg    <= last_c;
            len_pos_reg <= len_c > 17'sd0;
            ctx_idx_reg <= '0;
            used_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            full_reg    <= 1'b0;
        end
        if (cmd.ctx_next) begin
            ctx_idx_reg <= ctx_idx_reg + SLOT_W'(1);
        end
        if (cmd.full) begin
            full_reg <= 1'b1;
        end
        if (cmd.hit) begin
            slot_reg    <= ctx_idx_reg;
            hv_work_reg <= hv_rdata_reg;
            k_reg       <= '0;
        end
        if (cmd.open) begin
            slot_reg    <= free_ctx;
            hv_work_reg <= MAX_HOLES'(1);
            k_reg       <= '0;
        end
        if (cmd.hole_next) begin
            k_reg <= k_reg + HOLE_W'(1);
        end
        if (cmd.hole_eval) begin
            hv_work_reg  <= hv_work_next;
            wr2_k_reg    <= free_hole;
            wr2_data_reg <= upper_piece;
            if (touched) begin
                used_reg <= 1'b1;
                if (low && high && !free_found) begin
                    ovf_reg <= 1'b1;
                end
            end
        end
        if (cmd.finish) begin
            if (full_reg) begin
                m_data_reg <= '{context_slot: 3'd0, fragment_used: 1'b0,
                                datagram_complete: 1'b0, status: STS_FULL};
            end else begin
                m_data_reg <= '{context_slot: 3'(slot_reg), fragment_used: used_reg,
                                datagram_complete: !remaining, status: status_c};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_last_reg    <= 16'hFFFF;
            store_limit_reg <= 16'hFFFF;
            ctx_valid_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_addr == REG_MAX_DATAGRAM_LAST) begin
                max_last_reg <= cfg_data;
            end
            if (cfg_valid && cfg_addr == REG_STORE_LIMIT) begin
                store_limit_reg <= cfg_data;
            end
            if (cmd.open) begin
                ctx_valid_reg[free_ctx] <= 1'b1;
            end
            if (cmd.finish && !full_reg) begin
                ctx_valid_reg[slot_reg] <= remaining;
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.key_match   = ctx_valid_reg[ctx_idx_reg] && (key_rdata_reg == key_in);
    assign sts.ctx_last    = ctx_idx_reg == SLOT_W'(NUM_CONTEXTS - 1);
    assign sts.ctx_free    = ~&ctx_valid_reg;
    assign sts.hole_active = hv_work_reg[k_reg] && len_pos_reg;
    assign sts.hole_last   = k_reg == HOLE_W'(MAX_HOLES - 1);
    assign sts.wr2_needed  = touched && low && high && free_found;
    assign sts.out_free    = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

FILE: rtl/core/ip_fragment_hole_tracker.sv
// Steps: a key read and a compare per context searched, an open state for a new context, a
// read state per hole entry plus an evaluate state per live hole and a second write per split that
// takes a second hole entry, then a done state that registers the result; a full table skips the walk.
// Throughput: one item at a time; the next item is taken in the cycle after the result is
// registered, and a new result waits in the last state while the previous one is stalled.
// Reset sets the configuration registers to 65535 and clears all context valid bits and the result valid flag.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IP fragment hole tracker
// Tracks reassembly holes of IPv4 fragments per context and reports completion.
// ----------------------------------------------------------------------------
module ip_fragment_hole_tracker import fht_pkg::*; #(
    parameter int NUM_CONTEXTS = NUM_CONTEXTS_DEF,
    parameter int MAX_HOLES    = MAX_HOLES_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire fht_in_t               s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output fht_out_t                   m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    fht_cmd_t cmd;
    fht_sts_t sts;

    assign cfg_ready = 1'b1;

    fht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    fht_datapath #(
        .NUM_CONTEXTS (NUM_CONTEXTS),
        .MAX_HOLES    (MAX_HOLES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
`default_nettype wire

FILE: rtl/core/fht_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IP fragment hole tracker checker
// Port level checks on result items, bound to the top level.
// ----------------------------------------------------------------------------
module fht_checker import fht_pkg::*; (
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire fht_out_t m_data
);

    // A stalled result item holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A full table gives a neutral result.
    a_full_neutral: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STS_FULL |->
            m_data.context_slot == 3'd0 && !m_data.fragment_used
            && !m_data.datagram_complete)
        else $error("table full result carries data");

    // A datagram can only complete through a fragment that filled a hole.
    a_complete_used: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.datagram_complete |-> m_data.fragment_used)
        else $error("completion without a used fragment");

    // Overflow and beyond store only arise from a used fragment.
    a_flag_used: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STS_OVERFLOW || m_data.status == STS_BEYOND)
            |-> m_data.fragment_used)
        else $error("store flag without a used fragment");

endmodule

bind ip_fragment_hole_tracker fht_checker u_fht_checker (.*);
`default_nettype wire
